[hw/rtl/gcnl_pkg.sv]
// Package for the grid cell neighbor locator.
// Holds the shared constants, the register codes, the payload and queue structs
// and the state types. It depends on nothing.
package gcnl_pkg;

  localparam int unsigned MAX_CELLS_PER_AXIS = 256;
  localparam int unsigned CNT_W    = 9;   // width of a cell count register
  localparam int unsigned CS_W     = 31;  // width of a cell size register
  localparam int unsigned COORD_W  = $clog2(MAX_CELLS_PER_AXIS);
  localparam int unsigned PT_W     = 32;
  localparam int unsigned IDX_W    = 24;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned EXT_W    = CNT_W + CS_W;      // extent product width (count times cell size)
  localparam int unsigned REM_W    = EXT_W + 2;         // signed work width
  localparam int unsigned CXY_W    = 2 * CNT_W;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = CS_W;
  localparam int unsigned DIV_STEPS = CNT_W;            // quotient bits
  localparam int unsigned STEP_W   = $clog2(DIV_STEPS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(8);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_SIZE_X    = 3'd0,
    REG_CELL_SIZE_Y    = 3'd1,
    REG_CELL_SIZE_Z    = 3'd2,
    REG_CELLS_ALONG_X  = 3'd3,
    REG_CELLS_ALONG_Y  = 3'd4,
    REG_CELLS_ALONG_Z  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic signed [PT_W-1:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic              in_range;
    logic [IDX_W-1:0]  cell_index;
    logic [SLOT_W-1:0] neighbor_slot;
    logic [IDX_W-1:0]  neighbor_index;
    logic              neighbor_valid;
    logic              last_result;
  } out_item_t;

  // Configuration as seen by the front and back parts, with derived products.
  typedef struct packed {
    logic [2:0][CS_W-1:0]  cell_size;
    logic [2:0][CNT_W-1:0] cell_cnt;
    logic [2:0][EXT_W-1:0] extent;    // count times cell size per axis
    logic [CXY_W-1:0]      cnt_xy;    // cells in one z slice
  } cfg_t;

  // Classified point handed from the front part to the back part.
  typedef struct packed {
    logic               ok;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] cz;
  } entry_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIV,
    FE_PUSH
  } fe_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_SUM,
    BK_EMIT,
    BK_ERR
  } bk_state_t;

endpackage

[hw/rtl/gcnl_stream_if.sv]
// Valid/ready stream interface used by both channels of the locator.
// The payload type is a parameter; it depends on nothing else.
interface gcnl_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/gcnl_front.sv]
// Front part: accepts points, checks the box bounds and finds the cell
// coordinates with a restoring divider per axis, one quotient bit per cycle.
// Depends on gcnl_pkg.
module gcnl_front import gcnl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  push,
  output entry_t                push_data,
  input  logic                  q_full
);

  fe_state_t                       state_r, state_nxt;
  logic [STEP_W-1:0]               step_r;
  logic [2:0]                      ok_r;
  logic [2:0][REM_W-1:0]           rem_r;
  logic [2:0][DIV_STEPS-1:0]       quo_r;
  logic                            accept;
  logic [2:0][PT_W-1:0]            pt;
  logic [2:0]                      ok_in;
  logic [2:0][REM_W-1:0]           off_in;
  logic [2:0][REM_W-1:0]           rem_step;
  logic [2:0]                      qbit;
  logic [2:0]                      fits;

  assign pt[0] = in_data.point_x;
  assign pt[1] = in_data.point_y;
  assign pt[2] = in_data.point_z;

  // Bounds test and offset into the box, per axis.
  always_comb begin
    logic signed [REM_W-1:0] p2;
    logic signed [REM_W-1:0] ws;
    for (int a = 0; a < 3; a++) begin
      p2 = {{(REM_W-PT_W-1){pt[a][PT_W-1]}}, pt[a], 1'b0};
      ws = {2'b00, cfg.extent[a]};
      ok_in[a]  = (p2 <= ws) && (p2 >= -ws) && (cfg.cell_size[a] != '0)
                  && (cfg.cell_cnt[a] != '0);
      off_in[a] = p2 + ws;
    end
  end

  // One restoring division step per axis: divisor is twice the cell size.
  always_comb begin
    logic [REM_W-1:0] shifted;
    logic [REM_W-1:0] trial;
    for (int a = 0; a < 3; a++) begin
      shifted = REM_W'({cfg.cell_size[a], 1'b0}) << (STEP_W'(DIV_STEPS - 1) - step_r);
      trial   = rem_r[a] - shifted;
      qbit[a] = !trial[REM_W-1];
      rem_step[a] = qbit[a] ? trial : rem_r[a];
      fits[a] = {quo_r[a]} < cfg.cell_cnt[a];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FE_IDLE: if (in_valid) state_nxt = FE_DIV;
      FE_DIV:  if (step_r == STEP_W'(DIV_STEPS - 1)) state_nxt = FE_PUSH;
      FE_PUSH: begin
        if (!q_full) state_nxt = in_valid ? FE_DIV : FE_IDLE;
      end
      default: state_nxt = FE_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready = 1'b0;
    push     = 1'b0;
    unique case (state_r)
      FE_IDLE: in_ready = 1'b1;
      FE_DIV:  in_ready = 1'b0;
      FE_PUSH: begin
        push     = !q_full;
        in_ready = !q_full;
      end
      default: in_ready = 1'b0;
    endcase
  end

  assign accept = in_valid && in_ready;

  assign push_data.ok = (&ok_r) && (&fits);
  assign push_data.cx = quo_r[0][COORD_W-1:0];
  assign push_data.cy = quo_r[1][COORD_W-1:0];
  assign push_data.cz = quo_r[2][COORD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Divider datapath.
  always_ff @(posedge clk) begin
    if (accept) begin
      step_r <= '0;
      ok_r   <= ok_in;
      rem_r  <= off_in;
      quo_r  <= '0;
    end else if (state_r == FE_DIV) begin
      step_r <= step_r + STEP_W'(1);
      rem_r  <= rem_step;
      for (int a = 0; a < 3; a++) begin
        quo_r[a] <= {quo_r[a][DIV_STEPS-2:0], qbit[a]};
      end
    end
  end

endmodule

[hw/rtl/gcnl_queue.sv]
// Two-entry queue between the front and back parts.
// Depends on gcnl_pkg for the entry type.
module gcnl_queue import gcnl_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  input  logic   pop,
  output entry_t pop_data,
  output logic   empty
);

  entry_t     mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;

  assign full     = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;
  assign pop_data = mem_r[rptr_r];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= !wptr_r;
      if (pop)  rptr_r <= !rptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

[hw/rtl/gcnl_back.sv]
// Back part: turns a classified point into its own cell index and walks the
// nine neighbors of its y plane into an output register. Depends on gcnl_pkg.
module gcnl_back import gcnl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_empty,
  input  entry_t    q_data,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  bk_state_t          state_r, state_nxt;
  entry_t             ent_r;
  logic [IDX_W-1:0]   pz_r, py_r;
  logic [IDX_W-1:0]   own_r, nidx_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [1:0]         dx_r, dz_r;
  logic               out_valid_r;
  out_item_t          out_r;
  logic               out_free;
  logic               load_nb;
  logic               load_err;
  logic [IDX_W-1:0]   own_sum;
  logic [COORD_W+1:0] nx, nz;
  logic               nb_valid;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign own_sum = pz_r + py_r + IDX_W'(ent_r.cx);
  assign nx = (COORD_W+2)'(ent_r.cx) + (COORD_W+2)'(dx_r) - (COORD_W+2)'(1);
  assign nz = (COORD_W+2)'(ent_r.cz) + (COORD_W+2)'(dz_r) - (COORD_W+2)'(1);
  assign nb_valid = (nx < (COORD_W+2)'(cfg.cell_cnt[0]))
                 && (nz < (COORD_W+2)'(cfg.cell_cnt[2]));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (!q_empty) state_nxt = q_data.ok ? BK_MUL : BK_ERR;
      BK_MUL:  state_nxt = BK_SUM;
      BK_SUM:  state_nxt = BK_EMIT;
      BK_EMIT: if (out_free && slot_r == LAST_SLOT) state_nxt = BK_IDLE;
      BK_ERR:  if (out_free) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    pop      = 1'b0;
    load_nb  = 1'b0;
    load_err = 1'b0;
    unique case (state_r)
      BK_IDLE: pop = !q_empty;
      BK_MUL:  pop = 1'b0;
      BK_SUM:  pop = 1'b0;
      BK_EMIT: load_nb = out_free;
      BK_ERR:  load_err = out_free;
      default: pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_nb || load_err) out_valid_r <= 1'b1;
      else if (out_ready)      out_valid_r <= 1'b0;
    end
  end

  // Index arithmetic and neighbor walk.
  always_ff @(posedge clk) begin
    if (pop) ent_r <= q_data;
    if (state_r == BK_MUL) begin
      pz_r <= IDX_W'(ent_r.cz) * IDX_W'(cfg.cnt_xy);
      py_r <= IDX_W'(ent_r.cy) * IDX_W'(cfg.cell_cnt[0]);
    end
    if (state_r == BK_SUM) begin
      own_r  <= own_sum;
      nidx_r <= own_sum - IDX_W'(cfg.cnt_xy) - IDX_W'(1);
      slot_r <= '0;
      dx_r   <= '0;
      dz_r   <= '0;
    end
    if (load_nb) begin
      slot_r <= slot_r + SLOT_W'(1);
      if (dx_r == 2'd2) begin
        dx_r   <= '0;
        dz_r   <= dz_r + 2'd1;
        nidx_r <= nidx_r + IDX_W'(cfg.cnt_xy) - IDX_W'(2);
      end else begin
        dx_r   <= dx_r + 2'd1;
        nidx_r <= nidx_r + IDX_W'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (load_nb) begin
      out_r.in_range       <= 1'b1;
      out_r.cell_index     <= own_r;
      out_r.neighbor_slot  <= slot_r;
      out_r.neighbor_index <= nb_valid ? nidx_r : '0;
      out_r.neighbor_valid <= nb_valid;
      out_r.last_result    <= slot_r == LAST_SLOT;
    end else if (load_err) begin
      out_r.in_range       <= 1'b0;
      out_r.cell_index     <= '0;
      out_r.neighbor_slot  <= '0;
      out_r.neighbor_index <= '0;
      out_r.neighbor_valid <= 1'b0;
      out_r.last_result    <= 1'b1;
    end
  end

endmodule

[hw/rtl/grid_cell_neighbor_locator_unit.sv]
// Grid cell neighbor locator: locates a Q16.16 point in an origin-centered
// uniform grid and lists the neighbor cells of its y plane.
//
// Channels: in_chan carries one point (x, y, z) per item; out_chan carries
// result items. A point inside the grid gives nine items, slots 0 to 8, the
// last one flagged by last_result; a point outside gives one item with
// in_range low. The cfg_ port writes the six grid registers; write it only
// while no point is in flight.
// Flow: the front part accepts a point, then runs nine divider steps, one
// quotient bit per cycle on all three axes, and takes no new point until it
// has pushed the last. The back part works through pop, multiply, sum and
// nine results per in-range point and is the slower part, which sets the
// sustained rate; for out-of-range points the front part sets the rate.
// A two-entry queue lets the front keep working while the receiver stalls;
// a stalled result holds in the output register until taken.
// Reset (synchronous, active low) empties the pipeline and restores cell
// sizes of 1.0 and counts of one.
// Depends on gcnl_pkg, gcnl_stream_if, gcnl_front, gcnl_queue and gcnl_back.
module grid_cell_neighbor_locator_unit import gcnl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  gcnl_stream_if.sink           in_chan,
  gcnl_stream_if.source         out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [2:0][CS_W-1:0]  cs_r, cs_nxt;
  logic [2:0][CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2:0][EXT_W-1:0] ext_r;
  logic [CXY_W-1:0]      cxy_r;
  logic [CNT_W-1:0]      cnt_clamped;
  cfg_t                  cfg;
  logic                  push, q_full, pop, q_empty;
  entry_t                push_data, pop_data;

  assign cnt_clamped = (cfg_data[CNT_W-1:0] > CNT_W'(MAX_CELLS_PER_AXIS))
                     ? CNT_W'(MAX_CELLS_PER_AXIS) : cfg_data[CNT_W-1:0];

  // Next values of the configuration registers.
  always_comb begin
    cs_nxt  = cs_r;
    cnt_nxt = cnt_r;
    if (!rst_n) begin
      cs_nxt  = {3{CS_W'(65536)}};
      cnt_nxt = {3{CNT_W'(1)}};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CELL_SIZE_X:   cs_nxt[0]  = cfg_data;
        REG_CELL_SIZE_Y:   cs_nxt[1]  = cfg_data;
        REG_CELL_SIZE_Z:   cs_nxt[2]  = cfg_data;
        REG_CELLS_ALONG_X: cnt_nxt[0] = cnt_clamped;
        REG_CELLS_ALONG_Y: cnt_nxt[1] = cnt_clamped;
        REG_CELLS_ALONG_Z: cnt_nxt[2] = cnt_clamped;
        default: ;
      endcase
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    cs_r  <= cs_nxt;
    cnt_r <= cnt_nxt;
  end

  // Derived products are built from the next register values, so they change
  // at the same edge as the registers and the very next item sees both.
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      ext_r[a] <= EXT_W'(cnt_nxt[a]) * EXT_W'(cs_nxt[a]);
    end
    cxy_r <= CXY_W'(cnt_nxt[0]) * CXY_W'(cnt_nxt[1]);
  end

  assign cfg.cell_size = cs_r;
  assign cfg.cell_cnt  = cnt_r;
  assign cfg.extent    = ext_r;
  assign cfg.cnt_xy    = cxy_r;

  gcnl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_data   (in_chan.data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  gcnl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  gcnl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_chan.data)
  );

endmodule

[hw/rtl/gcnl_checker.sv]
// Port-level checks for the grid cell neighbor locator, bound to the top level.
// Depends on gcnl_pkg for the result type.
module gcnl_checker import gcnl_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // An out-of-range result is a single, zeroed item.
  a_err_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.in_range |-> out_data.last_result
      && out_data.cell_index == '0 && out_data.neighbor_index == '0
      && !out_data.neighbor_valid)
    else $error("malformed out-of-range result");

  // Invalid neighbors carry index zero.
  a_nb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.neighbor_valid |-> out_data.neighbor_index == '0)
    else $error("invalid neighbor with nonzero index");

  // The final slot and only it closes an in-range point.
  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.in_range |->
      out_data.last_result == (out_data.neighbor_slot == LAST_SLOT))
    else $error("last_result does not match slot");

endmodule

bind grid_cell_neighbor_locator_unit gcnl_checker u_gcnl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);

[sim/tb.sv]
// Self-checking testbench for grid_cell_neighbor_locator_unit.
// Drives Q16.16 points and grid settings, predicts every result item itself.
// Depends on gcnl_pkg, gcnl_stream_if and the RTL of the locator.
module tb import gcnl_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 3000;
  localparam int DRAIN_CYCLES = 30;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0] SPARE_REG_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] SPARE_REG_B = 3'd7;
  localparam longint IDX_MASK = 64'hFF_FFFF;

  // A row of the directed part; oor rows carry a typed out-of-range result.
  typedef struct {
    in_item_t pt;
    bit oor;
  } point_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gcnl_stream_if #(.payload_t(in_item_t)) in_if();
  gcnl_stream_if #(.payload_t(out_item_t)) out_if();

  grid_cell_neighbor_locator_unit dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_if), .out_chan(out_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Grid settings as the block should hold them.
  logic [CS_W-1:0] grid_size[3];
  logic [CNT_W-1:0] grid_cnt[3];

  out_item_t pending_cells[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_req = 1'b0;
  int quiet_cycles = 0;

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  // Locate one coordinate on one axis; returns 1 when on the grid.
  function automatic bit locate(input logic signed [PT_W-1:0] raw,
                                input logic [CS_W-1:0] size,
                                input logic [CNT_W-1:0] cnt,
                                output longint coord);
    longint p2, w, q;
    coord = 0;
    if (size == 0 || cnt == 0) return 1'b0;
    p2 = longint'(raw) * 2;
    w = longint'(cnt) * longint'(size);
    if (p2 > w || p2 < -w) return 1'b0;
    q = (p2 + w) / (2 * longint'(size));
    if (q >= longint'(cnt)) return 1'b0;
    coord = q;
    return 1'b1;
  endfunction

  function automatic longint cell_number(input longint x, input longint y, input longint z);
    return (z * grid_cnt[0] * grid_cnt[1] + y * grid_cnt[0] + x) & IDX_MASK;
  endfunction

  // Queue the result items that one accepted point should produce.
  function automatic void predict_cells(input in_item_t p);
    longint x, y, z, nx, nz;
    bit ok;
    out_item_t r;
    ok = locate(p.point_x, grid_size[0], grid_cnt[0], x);
    ok = ok && locate(p.point_y, grid_size[1], grid_cnt[1], y);
    ok = ok && locate(p.point_z, grid_size[2], grid_cnt[2], z);
    if (!ok) begin
      r = '0;
      r.last_result = 1'b1;
      pending_cells.push_back(r);
      return;
    end
    for (int s = 0; s < 9; s++) begin
      nx = x + (s % 3) - 1;
      nz = z + (s / 3) - 1;
      r.in_range = 1'b1;
      r.cell_index = IDX_W'(cell_number(x, y, z));
      r.neighbor_slot = SLOT_W'(s);
      r.neighbor_valid = nx >= 0 && nx < grid_cnt[0] && nz >= 0 && nz < grid_cnt[2];
      r.neighbor_index = r.neighbor_valid ? IDX_W'(cell_number(nx, y, nz)) : '0;
      r.last_result = (s == 8);
      pending_cells.push_back(r);
    end
  endfunction

  // Write one register while the block is idle and track it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_CELL_SIZE_X: grid_size[0] = val;
      REG_CELL_SIZE_Y: grid_size[1] = val;
      REG_CELL_SIZE_Z: grid_size[2] = val;
      REG_CELLS_ALONG_X: grid_cnt[0] = (val[8:0] > 256) ? 9'd256 : val[8:0];
      REG_CELLS_ALONG_Y: grid_cnt[1] = (val[8:0] > 256) ? 9'd256 : val[8:0];
      REG_CELLS_ALONG_Z: grid_cnt[2] = (val[8:0] > 256) ? 9'd256 : val[8:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_cells.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Offer one point and wait until it is taken; typed rows skip the predictor.
  task automatic send_point(input in_item_t p, input bit oor_typed);
    out_item_t r;
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= p;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (oor_typed) begin
      r = '0;
      r.last_result = 1'b1;
      pending_cells.push_back(r);
    end else begin
      predict_cells(p);
    end
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_if.valid <= 1'b0;
  endtask

  // A coordinate mostly inside the box of one axis, sometimes anything at all.
  function automatic logic signed [PT_W-1:0] pick_coord(input int axis);
    longint half;
    half = (longint'(grid_cnt[axis]) * longint'(grid_size[axis])) / 2;
    if (half == 0 || half >= 64'h7FFF_FFFF || $urandom_range(3) == 0)
      return $urandom;
    return PT_W'(longint'($urandom_range(0, 32'(2 * half))) - half);
  endfunction

  task automatic random_points(input int n);
    in_item_t p;
    for (int i = 0; i < n; i++) begin
      p.point_x = pick_coord(0);
      p.point_y = pick_coord(1);
      p.point_z = pick_coord(2);
      send_point(p, 1'b0);
    end
    end_burst();
  endtask

  task automatic random_grid();
    logic [CFG_DATA_W-1:0] s;
    logic [CFG_DATA_W-1:0] c;
    for (int a = 0; a < 3; a++) begin
      s = CFG_DATA_W'($urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 30));
      if (s == 0) s = 1;
      c = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(1, 256))
                                      : CFG_DATA_W'($urandom_range(1, 8));
      write_reg(CFG_IDX_W'(a), s);
      write_reg(CFG_IDX_W'(a + 3), c);
    end
  endtask

  task automatic directed_rows(input point_row_t rows[]);
    foreach (rows[i]) send_point(rows[i].pt, rows[i].oor);
    end_burst();
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      out_if.ready <= 1'b0;
      for (int i = 0; i < HOLD_CYCLES; i++) @(negedge clk);
      hold_req = 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Compare every result item with the oldest expectation.
  always @(posedge clk) begin
    out_item_t e, g;
    if (rst_n && out_if.valid && out_if.ready) begin
      g = out_if.data;
      if (pending_cells.size() == 0) begin
        $display("%0t unexpected result item: %p", $realtime, g);
        errors++;
      end else begin
        e = pending_cells.pop_front();
        if (g.in_range !== e.in_range)
          $display("%0t in_range exp %0d got %0d", $realtime, e.in_range, g.in_range);
        if (g.cell_index !== e.cell_index)
          $display("%0t cell_index exp %0d got %0d", $realtime, e.cell_index, g.cell_index);
        if (g.neighbor_slot !== e.neighbor_slot)
          $display("%0t neighbor_slot exp %0d got %0d", $realtime, e.neighbor_slot,
                   g.neighbor_slot);
        if (g.neighbor_index !== e.neighbor_index)
          $display("%0t neighbor_index exp %0d got %0d", $realtime, e.neighbor_index,
                   g.neighbor_index);
        if (g.neighbor_valid !== e.neighbor_valid)
          $display("%0t neighbor_valid exp %0d got %0d", $realtime, e.neighbor_valid,
                   g.neighbor_valid);
        if (g.last_result !== e.last_result)
          $display("%0t last_result exp %0d got %0d", $realtime, e.last_result, g.last_result);
        if (g !== e) errors++;
      end
    end
  end

  // Watchdog: too long without any item moving on either channel.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    point_row_t reset_rows[];
    point_row_t small_rows[];
    grid_size = '{32'd65536, 32'd65536, 32'd65536};
    grid_cnt = '{9'd1, 9'd1, 9'd1};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset grid: one cell of 1.0 around the origin, faces and extremes.
    reset_rows = '{
      '{'{32'sd0, 32'sd0, 32'sd0}, 1'b0},
      '{'{-32'sd32768, -32'sd32768, -32'sd32768}, 1'b0},
      '{'{32'sd32767, 32'sd32767, 32'sd32767}, 1'b0},
      '{'{32'sd32768, 32'sd0, 32'sd0}, 1'b1},
      '{'{32'sd0, 32'sd0, 32'sd32768}, 1'b1},
      '{'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF}, 1'b1},
      '{'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}, 1'b1},
      '{'{32'sd0, -32'sd32769, 32'sd0}, 1'b1}
    };
    directed_rows(reset_rows);
    drain();

    // Three by three by three grid, taller cells along y.
    write_reg(REG_CELLS_ALONG_X, 3);
    write_reg(REG_CELLS_ALONG_Y, 3);
    write_reg(REG_CELLS_ALONG_Z, 3);
    write_reg(REG_CELL_SIZE_Y, 131072);
    small_rows = '{
      '{'{32'sd0, 32'sd0, 32'sd0}, 1'b0},
      '{'{-32'sd98304, -32'sd196608, -32'sd98304}, 1'b0},
      '{'{32'sd98303, 32'sd196607, 32'sd98303}, 1'b0},
      '{'{32'sd98303, 32'sd0, -32'sd98304}, 1'b0},
      '{'{-32'sd98304, 32'sd100000, 32'sd98303}, 1'b0},
      '{'{32'sd40000, -32'sd70000, 32'sd0}, 1'b0},
      '{'{32'sd98304, 32'sd0, 32'sd0}, 1'b1},
      '{'{32'sd0, 32'sd196608, 32'sd0}, 1'b1},
      '{'{-32'sd98305, 32'sd0, 32'sd0}, 1'b1},
      '{'{32'sd0, 32'sd0, 32'sh8000_0000}, 1'b1}
    };
    directed_rows(small_rows);
    drain();

    // Largest grid, largest cells; an oversized count must saturate.
    for (int a = 0; a < 3; a++) write_reg(CFG_IDX_W'(a), 31'h7FFF_FFFF);
    write_reg(REG_CELLS_ALONG_X, 511);
    write_reg(REG_CELLS_ALONG_Y, 256);
    write_reg(REG_CELLS_ALONG_Z, 300);
    random_points(35);
    drain();

    // Smallest cells on the largest grid; sender idles.
    send_idle = 64;
    for (int a = 0; a < 3; a++) write_reg(CFG_IDX_W'(a), 1);
    random_points(35);
    drain();

    // Random grids under receiver stalls, then both sides idling.
    send_idle = 0;
    recv_idle = 64;
    random_grid();
    random_points(40);
    drain();
    send_idle = 38;
    recv_idle = 38;
    random_grid();
    random_points(40);
    drain();

    // Long receiver hold-off while the sender keeps offering.
    send_idle = 0;
    recv_idle = 0;
    random_grid();
    hold_req = 1'b1;
    random_points(40);
    drain();

    // Zero size and zero count make axes unusable; spare indexes are ignored.
    write_reg(REG_CELL_SIZE_X, 0);
    write_reg(SPARE_REG_A, 31'h1234_5678);
    random_points(6);
    drain();
    write_reg(REG_CELL_SIZE_X, 65536);
    write_reg(REG_CELLS_ALONG_Z, 0);
    write_reg(SPARE_REG_B, 31'h7FFF_FFFF);
    random_points(6);
    drain();

    // Final random stretch with both sides idling.
    send_idle = 38;
    recv_idle = 38;
    random_grid();
    random_points(45);
    drain();

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

[sim.f]
hw/rtl/gcnl_pkg.sv
hw/rtl/gcnl_stream_if.sv
hw/rtl/gcnl_front.sv
hw/rtl/gcnl_queue.sv
hw/rtl/gcnl_back.sv
hw/rtl/grid_cell_neighbor_locator_unit.sv
hw/rtl/gcnl_checker.sv
sim/tb.sv
